@@ src/ocv_pkg.sv @@
package ocv_pkg;

  localparam int NUM_ITEMS_DEF = 16;
  localparam int MAX_TXNS_DEF  = 8;

  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;
  localparam logic [1:0] KIND_COMMIT = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         txn_slot;
    logic [3:0]         item_index;
    logic signed [31:0] write_value;
  } op_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               outcome;
  } res_t;

  typedef struct packed {
    logic accept;
    logic begin_clr;
    logic buf_wr;
    logic set_rd;
    logic set_wr;
    logic cset;
    logic walk_start;
    logic walk_en;
    logic p1;
    logic p2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] in_kind;
    logic       in_slot_ok;
    logic       in_item_ok;
    logic       walk_done;
    logic       abort;
  } sts_t;

endpackage

@@ src/optimistic_commit_validator.sv @@
// Commit validator for forward optimistic concurrency control.
// Channel op (op_valid/op_ready): one operation per handshake, a kind
// (begin, read, write, commit), a transaction slot, an item index and a
// write value. Channel res (res_valid/res_ready): exactly one result per
// operation, in order: the committed value for a read (else zero) and the
// outcome bit, set when a commit aborts.
// One operation is in flight at a time. Begin and ignored operations go
// straight to the response state, a read or a write first updates the
// slot's sets, and a commit walks the reader-mark memory and then the
// slot's write buffer, one item per cycle each; a commit that aborts
// skips the write buffer walk.
// op_ready is high once the previous result sits in the output register,
// even while res_ready is low; a stalled receiver holds the block in its
// response state until the output register frees up.
// Reset (rst, synchronous) clears item values, reader marks and the slot
// sets through valid bits at once; no clearing pass is needed.
module optimistic_commit_validator #(
  parameter int NUM_ITEMS = ocv_pkg::NUM_ITEMS_DEF,
  parameter int MAX_TXNS  = ocv_pkg::MAX_TXNS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  ocv_pkg::op_t  op,
  output logic          res_valid,
  input  logic          res_ready,
  output ocv_pkg::res_t res
);

  import ocv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ocv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ocv_datapath #(.NUM_ITEMS(NUM_ITEMS), .MAX_TXNS(MAX_TXNS)) u_datapath (
    .clk (clk),
    .rst (rst),
    .op  (op),
    .cmd (cmd),
    .sts (sts),
    .res (res)
  );

endmodule

@@ src/ocv_ram.sv @@
module ocv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/ocv_datapath.sv @@
module ocv_datapath #(
  parameter int NUM_ITEMS = 16,
  parameter int MAX_TXNS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  ocv_pkg::op_t  op,
  input  ocv_pkg::cmd_t cmd,
  output ocv_pkg::sts_t sts,
  output ocv_pkg::res_t res
);

  import ocv_pkg::*;

  localparam int ITEM_W    = $clog2(NUM_ITEMS);
  localparam int SLOT_W    = (MAX_TXNS > 1) ? $clog2(MAX_TXNS) : 1;
  localparam int CNT_W     = $clog2(NUM_ITEMS + 1);
  localparam int SET_W     = 2 * NUM_ITEMS;
  localparam int BUF_DEPTH = MAX_TXNS * NUM_ITEMS;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  logic [SLOT_W-1:0]    op_slot;
  logic [ITEM_W-1:0]    op_item;
  logic [SLOT_W-1:0]    slot_q;
  logic [ITEM_W-1:0]    item_q;
  logic [MAX_TXNS-1:0]  me;
  logic [NUM_ITEMS-1:0] item_bit;

  logic [MAX_TXNS-1:0]  set_vld;
  logic                 set_vld_q;
  logic [SET_W-1:0]     set_rdata;
  logic [SET_W-1:0]     set_row;
  logic [NUM_ITEMS-1:0] rs_row;
  logic [NUM_ITEMS-1:0] ws_row;
  logic                 set_we;
  logic [SET_W-1:0]     set_wdata;

  logic [NUM_ITEMS-1:0] rd_vld;
  logic                 rd_vld_q;
  logic [MAX_TXNS-1:0]  rdr_rdata;
  logic [MAX_TXNS-1:0]  rmap;
  logic [MAX_TXNS-1:0]  rmap_new;
  logic                 rdr_re;
  logic [ITEM_W-1:0]    rdr_raddr;
  logic                 rdr_we;
  logic [ITEM_W-1:0]    rdr_waddr;
  logic [MAX_TXNS-1:0]  rdr_wdata;

  logic [NUM_ITEMS-1:0] iv;
  logic                 iv_q;
  logic [31:0]          item_rdata;
  logic                 item_we;

  logic [BUF_AW-1:0]    buf_waddr;
  logic [BUF_AW-1:0]    buf_raddr;
  logic                 buf_re;
  logic [31:0]          buf_rdata;

  logic [NUM_ITEMS-1:0] rs_q;
  logic [NUM_ITEMS-1:0] ws_q;
  logic [CNT_W-1:0]     cnt;
  logic                 issue;
  logic                 stg_vld;
  logic [ITEM_W-1:0]    stg_idx;
  logic                 abort;
  logic [31:0]          value_q;

  assign op_slot  = SLOT_W'(op.txn_slot);
  assign op_item  = ITEM_W'(op.item_index);
  assign me       = MAX_TXNS'(1) << slot_q;
  assign item_bit = NUM_ITEMS'(1) << item_q;
  assign issue    = cnt < CNT_W'(NUM_ITEMS);

  assign sts.in_kind    = op.kind;
  assign sts.in_slot_ok = {29'd0, op.txn_slot} < 32'(MAX_TXNS);
  assign sts.in_item_ok = {28'd0, op.item_index} < 32'(NUM_ITEMS);
  assign sts.walk_done  = !issue && !stg_vld;
  assign sts.abort      = abort;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      slot_q <= op_slot;
      item_q <= op_item;
    end
  end

  // Read and write sets of each slot, one row per slot
  assign set_row   = set_vld_q ? set_rdata : '0;
  assign rs_row    = set_row[NUM_ITEMS-1:0];
  assign ws_row    = set_row[SET_W-1:NUM_ITEMS];
  assign set_we    = cmd.set_rd || cmd.set_wr;
  assign set_wdata = cmd.set_rd ? {ws_row, rs_row | item_bit} : {ws_row | item_bit, rs_row};

  ocv_ram #(.WIDTH(SET_W), .DEPTH(MAX_TXNS)) u_sets (
    .clk     (clk),
    .wr_en   (set_we),
    .wr_addr (slot_q),
    .wr_data (set_wdata),
    .rd_en   (cmd.accept),
    .rd_addr (op_slot),
    .rd_data (set_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      set_vld <= '0;
    end else begin
      if (cmd.begin_clr) begin
        set_vld[op_slot] <= 1'b0;
      end
      if (cmd.cset) begin
        set_vld[slot_q] <= 1'b0;
      end
      if (set_we) begin
        set_vld[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_vld_q <= set_vld[op_slot];
    end
  end

  // Reader marks, one row per item
  assign rmap      = rd_vld_q ? rdr_rdata : '0;
  assign rmap_new  = rs_q[stg_idx] ? (rmap & ~me) : rmap;
  assign rdr_re    = cmd.accept || (cmd.p1 && issue);
  assign rdr_raddr = cmd.accept ? op_item : cnt[ITEM_W-1:0];
  assign rdr_we    = cmd.set_rd || (cmd.p1 && stg_vld);
  assign rdr_waddr = cmd.set_rd ? item_q : stg_idx;
  assign rdr_wdata = cmd.set_rd ? (rmap | me) : rmap_new;

  ocv_ram #(.WIDTH(MAX_TXNS), .DEPTH(NUM_ITEMS)) u_readers (
    .clk     (clk),
    .wr_en   (rdr_we),
    .wr_addr (rdr_waddr),
    .wr_data (rdr_wdata),
    .rd_en   (rdr_re),
    .rd_addr (rdr_raddr),
    .rd_data (rdr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= '0;
    end else if (rdr_we) begin
      rd_vld[rdr_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdr_re) begin
      rd_vld_q <= rd_vld[rdr_raddr];
    end
  end

  // Committed item values
  assign item_we = cmd.p2 && stg_vld && ws_q[stg_idx];

  ocv_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS)) u_items (
    .clk     (clk),
    .wr_en   (item_we),
    .wr_addr (stg_idx),
    .wr_data (buf_rdata),
    .rd_en   (cmd.accept),
    .rd_addr (op_item),
    .rd_data (item_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= '0;
    end else if (item_we) begin
      iv[stg_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      iv_q <= iv[op_item];
    end
  end

  // Private write buffers, one block of items per slot
  assign buf_waddr = BUF_AW'(op_slot) * BUF_AW'(NUM_ITEMS) + BUF_AW'(op_item);
  assign buf_raddr = BUF_AW'(slot_q) * BUF_AW'(NUM_ITEMS) + BUF_AW'(cnt[ITEM_W-1:0]);
  assign buf_re    = cmd.p2 && issue;

  ocv_ram #(.WIDTH(32), .DEPTH(BUF_DEPTH)) u_wbuf (
    .clk     (clk),
    .wr_en   (cmd.buf_wr),
    .wr_addr (buf_waddr),
    .wr_data (op.write_value),
    .rd_en   (buf_re),
    .rd_addr (buf_raddr),
    .rd_data (buf_rdata)
  );

  // Item walk for commit
  always_ff @(posedge clk) begin
    if (cmd.cset) begin
      rs_q <= rs_row;
      ws_q <= ws_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      stg_vld <= 1'b0;
    end else if (cmd.walk_start) begin
      cnt     <= '0;
      stg_vld <= 1'b0;
    end else if (cmd.walk_en) begin
      stg_vld <= issue;
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_en && issue) begin
      stg_idx <= cnt[ITEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      abort <= 1'b0;
    end else if (cmd.accept) begin
      abort <= 1'b0;
    end else if (cmd.p1 && stg_vld && ws_q[stg_idx] && (rmap_new != '0)) begin
      abort <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value_q <= '0;
    end else if (cmd.set_rd) begin
      value_q <= iv_q ? item_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.read_value <= value_q;
      res.outcome    <= abort;
    end
  end

endmodule

@@ src/ocv_ctrl.sv @@
module ocv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  output logic          res_valid,
  input  logic          res_ready,
  input  ocv_pkg::sts_t sts,
  output ocv_pkg::cmd_t cmd
);

  import ocv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_CSET = 3'd3;
  localparam logic [2:0] S_P1   = 3'd4;
  localparam logic [2:0] S_P2   = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       res_valid_next;

  assign op_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (op_valid) begin
          cmd.accept = 1'b1;
          if (!sts.in_slot_ok) begin
            state_next = S_RESP;
          end else begin
            case (sts.in_kind)
              KIND_BEGIN: begin
                cmd.begin_clr = 1'b1;
                state_next    = S_RESP;
              end
              KIND_READ: begin
                state_next = sts.in_item_ok ? S_RD : S_RESP;
              end
              KIND_WRITE: begin
                cmd.buf_wr = sts.in_item_ok;
                state_next = sts.in_item_ok ? S_WR : S_RESP;
              end
              default: begin
                state_next = S_CSET;
              end
            endcase
          end
        end
      end
      S_RD: begin
        cmd.set_rd = 1'b1;
        state_next = S_RESP;
      end
      S_WR: begin
        cmd.set_wr = 1'b1;
        state_next = S_RESP;
      end
      S_CSET: begin
        cmd.cset       = 1'b1;
        cmd.walk_start = 1'b1;
        state_next     = S_P1;
      end
      S_P1: begin
        cmd.walk_en = 1'b1;
        cmd.p1      = 1'b1;
        if (sts.walk_done) begin
          if (sts.abort) begin
            state_next = S_RESP;
          end else begin
            cmd.walk_start = 1'b1;
            state_next     = S_P2;
          end
        end
      end
      S_P2: begin
        cmd.walk_en = 1'b1;
        cmd.p2      = 1'b1;
        if (sts.walk_done) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.out_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("op_ready stayed high after a transaction was accepted");

  a_no_copy_after_abort: assert property (@(posedge clk) disable iff (rst)
    state == S_P2 |-> !sts.abort)
    else $error("write buffer copy running for an aborted commit");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_RESP)
    else $error("result presented outside the response state");

  a_resp_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    state == S_RESP && res_valid && !res_ready |=> state == S_RESP)
    else $error("response state left while the output register was full");
`endif

endmodule
